@@ rtl/signed_int_to_decimal_ascii_defines.svh @@
// Assertion macros shared by the signed integer to decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SIDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SIDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SIDA_ASSERT_NOW(label, ante, cons)
`define SIDA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/sida_pkg.sv @@
// Shared types and constants for the signed integer to decimal text block.
`timescale 1ns / 1ps
package sida_pkg;

  localparam int ValueW    = 32;
  localparam int NumDigits = 10;
  localparam int DigitIdxW = $clog2(NumDigits);
  localparam int StepCntW  = $clog2(ValueW);
  localparam int CharW     = 8;

  localparam logic [CharW-1:0] CharMinus = 8'd45;
  localparam logic [CharW-1:0] CharZero  = 8'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_FIND,
    ST_EMIT_SIGN,
    ST_EMIT_DIGIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take a new word, form magnitude
    logic step;      // one shift-add-3 step
    logic find;      // locate most significant nonzero digit
    logic dec;       // move to next lower digit
    logic sign_sel;  // present '-' instead of a digit
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done; // current step is the last one
    logic neg;       // word was negative
    logic ptr_zero;  // pointing at the units digit
  } sts_t;

endpackage

@@ rtl/sida_datapath.sv @@
// Datapath: magnitude, double-dabble BCD register, digit pointer, byte select.
`timescale 1ns / 1ps
module sida_datapath (
  input  logic                                 clk_i,
  input  logic signed [sida_pkg::ValueW-1:0]   value_i,
  input  sida_pkg::cmd_t                       cmd_i,
  output sida_pkg::sts_t                       sts_o,
  output logic        [sida_pkg::CharW-1:0]    char_code_o,
  output logic                                 last_o
);
  import sida_pkg::*;

  logic [ValueW-1:0]    mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic [3:0]           bcd_q [NumDigits];
  logic [3:0]           bcd_d [NumDigits];
  logic [3:0]           adj   [NumDigits];
  logic [StepCntW-1:0]  cnt_q, cnt_d;
  logic [DigitIdxW-1:0] ptr_q, ptr_d;
  logic [DigitIdxW-1:0] msd_idx;
  logic [ValueW-1:0]    raw;

  assign raw = value_i;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      adj[k] = (bcd_q[k] >= 4'd5) ? 4'(bcd_q[k] + 4'd3) : bcd_q[k];
    end
  end

  // most significant nonzero digit, units digit when all are zero
  always_comb begin
    msd_idx = '0;
    for (int k = 1; k < NumDigits; k++) begin
      if (bcd_q[k] != 4'd0) begin
        msd_idx = DigitIdxW'(k);
      end
    end
  end

  // next state of the datapath registers
  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    for (int k = 0; k < NumDigits; k++) begin
      bcd_d[k] = bcd_q[k];
    end
    if (cmd_i.load) begin
      neg_d = raw[ValueW-1];
      mag_d = raw[ValueW-1] ? ValueW'(~raw + 1'b1) : raw;
      cnt_d = '0;
      for (int k = 0; k < NumDigits; k++) begin
        bcd_d[k] = 4'd0;
      end
    end else if (cmd_i.step) begin
      mag_d = {mag_q[ValueW-2:0], 1'b0};
      cnt_d = StepCntW'(cnt_q + 1'b1);
      bcd_d[0] = {adj[0][2:0], mag_q[ValueW-1]};
      for (int k = 1; k < NumDigits; k++) begin
        bcd_d[k] = {adj[k][2:0], adj[k-1][3]};
      end
    end else if (cmd_i.find) begin
      ptr_d = msd_idx;
    end else if (cmd_i.dec) begin
      ptr_d = DigitIdxW'(ptr_q - 1'b1);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
    ptr_q <= ptr_d;
    for (int k = 0; k < NumDigits; k++) begin
      bcd_q[k] <= bcd_d[k];
    end
  end

  // status back to the controller
  assign sts_o.conv_done = (cnt_q == StepCntW'(ValueW - 1));
  assign sts_o.neg       = neg_q;
  assign sts_o.ptr_zero  = (ptr_q == '0);

  // output byte straight from registers, steady while stalled
  assign char_code_o = cmd_i.sign_sel ? CharMinus
                                      : CharW'(CharZero + {4'd0, bcd_q[ptr_q]});
  assign last_o      = !cmd_i.sign_sel && (ptr_q == '0);

endmodule

@@ rtl/sida_ctrl.sv @@
// Controller: sequences load, conversion steps, digit search and byte output.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_defines.svh"
module sida_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  sida_pkg::sts_t sts_i,
  output sida_pkg::cmd_t cmd_o
);
  import sida_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd_o.step = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = sts_i.neg ? ST_EMIT_SIGN : ST_EMIT_DIGIT;
      end
      ST_EMIT_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sign_sel = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_EMIT_DIGIT;
        end
      end
      ST_EMIT_DIGIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.ptr_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.dec = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // checks
  `SIDA_ASSERT_NEXT(a_accept_starts_conv, in_valid_i && !in_stall_o, state_q == ST_CONVERT)
  `SIDA_ASSERT_NEXT(a_conv_then_find,
                    (state_q == ST_CONVERT) && sts_i.conv_done,
                    state_q == ST_FIND)
  `SIDA_ASSERT_NEXT(a_last_word_idles,
                    (state_q == ST_EMIT_DIGIT) && !out_stall_i && sts_i.ptr_zero,
                    state_q == ST_IDLE)
  `SIDA_ASSERT_NOW(a_dec_not_below_units, cmd_o.dec, !sts_i.ptr_zero)

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level: signed 32-bit integer to decimal ASCII text, one byte per transfer.
// An input word gives n = 1..11 bytes of text: an optional '-' and 1..10 digits.
// The 32-step shift-add-3 loop converts first; one word is in work at a time.
// First byte follows ST_CONVERT and ST_FIND; bytes leave one per cycle unless stalled.
// rst_ni clears the controller to idle asynchronously; datapath registers are not reset.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sida_pkg::ValueW-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [sida_pkg::CharW-1:0]   char_code_o,
  output logic                                last_o
);
  import sida_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sida_datapath u_datapath (
    .clk_i       (clk_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

@@ tb/tb_top.sv @@
// Testbench for signed_int_to_decimal_ascii: directed and random words, text checked per byte.
`timescale 1ns / 1ps
module tb_top;
  import sida_pkg::*;

  localparam int NumDirected = 16;
  localparam int NumRandom   = 200;
  localparam int NumWords    = NumDirected + NumRandom;
  localparam int QuietFrom   = NumWords - 40;  // no idling on either side from here on
  localparam int DrainAt     = NumDirected + 100;
  localparam int TailCycles  = 60;             // margin for any trailing output after the drain
  localparam int CycleLimit  = 200000;

  typedef struct {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [ValueW-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [CharW-1:0]         char_code_o;
  logic                     last_o;

  text_char_t  text_q[$];    // bytes still owed by the block, oldest first
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          quiet_phase;

  // Directed words; an empty string means the text comes from the predictor
  logic [ValueW-1:0] dir_value[NumDirected] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h8000_0001, 32'h0000_0009, 32'h0000_000A,
    32'hFFFF_FFF6, 32'd1000000000, -32'sd1000000000, 32'd999999999,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd12345, -32'sd98765
  };
  string dir_text[NumDirected] = '{
    "0", "-2147483648", "2147483647", "-1",
    "1", "-2147483647", "9", "10",
    "-10", "1000000000", "-1000000000", "999999999",
    "", "", "", ""
  };

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Expected decimal text of one word: sign, then digits most significant first
  function automatic void predict_text(input logic [ValueW-1:0] word);
    logic [ValueW-1:0] mag;
    logic [3:0]        digit_q[$];
    mag = word[ValueW-1] ? (32'd0 - word) : word;
    if (word[ValueW-1]) text_q.push_back('{code: CharMinus, last: 1'b0});
    do begin
      digit_q.push_front(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 0);
    for (int k = 0; k < digit_q.size(); k++) begin
      text_q.push_back('{code: CharZero + CharW'(digit_q[k]),
                         last: (k == digit_q.size() - 1)});
    end
  endfunction

  // Expected text typed in as a string
  function automatic void push_text(input string s);
    for (int k = 0; k < s.len(); k++) begin
      text_q.push_back('{code: CharW'(s[k]), last: (k == s.len() - 1)});
    end
  endfunction

  // Random word: full range, small magnitudes, powers of ten and neighbors, extremes
  function automatic logic [ValueW-1:0] pick_value();
    int                sel;
    int                small_val;
    logic [ValueW-1:0] p;
    sel = $urandom_range(0, 5);
    p = 32'd1;
    case (sel)
      0, 1: begin
        p = $urandom();
      end
      2: begin
        small_val = $urandom_range(0, 1998);
        p = 32'(small_val - 999);
      end
      3, 4: begin
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        p = p + 32'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 1) == 1) p = 32'd0 - p;
      end
      default: begin
        if ($urandom_range(0, 1) == 1) p = 32'h8000_0000 + 32'($urandom_range(0, 3));
        else p = 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      end
    endcase
    return p;
  endfunction

  // Output side: compare each accepted byte with the oldest expected one
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected byte %0d last %0b", $time, char_code_o, last_o);
      end else begin
        want = text_q.pop_front();
        if (char_code_o !== want.code || last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: byte mismatch: expected %0d last %0b, got %0d last %0b",
                     $time, want.code, want.last, char_code_o, last_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output stall in random bursts, none in the quiet phase
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat (quiet_phase ? 1 : $urandom_range(1, 15)) @(posedge clk_i);
    end
  end

  // Reset, then send every word
  initial begin
    logic [ValueW-1:0] word;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    mismatches  = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NumWords; n++) begin
      if (n == QuietFrom) quiet_phase = 1'b1;
      word = (n < NumDirected) ? dir_value[n] : pick_value();
      in_valid_i <= 1'b1;
      value_i    <= word;
      do @(posedge clk_i); while (in_stall_o);
      // word taken at this edge
      if (n < NumDirected && dir_text[n] != "") push_text(dir_text[n]);
      else predict_text(word);

      // hold off until the block has drained, once after the directed words and once mid-run
      if (n == NumDirected - 1 || n == DrainAt) begin
        in_valid_i <= 1'b0;
        while (text_q.size() != 0) @(posedge clk_i);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // drain, then allow for any trailing output
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && text_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
